### rtl/core/disk_image_header_validator_assert.svh
// assertion macros for the disk image header validator
`ifndef DISK_IMAGE_HEADER_VALIDATOR_ASSERT_SVH
`define DISK_IMAGE_HEADER_VALIDATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked property, disabled while reset is asserted
`define DIHV_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("dihv assertion failed");

// same, with a message of its own
`define DIHV_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

`else

`define DIHV_ASSERT(lbl, clk, rstn, prop)
`define DIHV_ASSERT_MSG(lbl, clk, rstn, prop, msg)

`endif

`endif

### rtl/core/dihv_pkg.sv
`default_nettype none

package dihv_pkg;

	localparam int HDR_LEN    = 46;
	localparam int BANNER_LEN = 21;
	localparam int LAST_IDX   = 45;

	// version string offsets
	localparam int VER_MAJOR  = 21;
	localparam int VER_DOT_AT = 22;
	localparam int VER_MIN_HI = 23;
	localparam int VER_MIN_LO = 24;
	localparam int VER_NUL_AT = 25;

	// low byte offsets of the little-endian geometry fields
	localparam int CYL_LO     = 30;
	localparam int HEADS_LO   = 32;
	localparam int SECT_LO    = 34;
	localparam int SSIZE_LO   = 42;
	localparam int TRACK_LO   = 44;

	localparam logic [7:0] CHR_DOT  = 8'h2E;
	localparam logic [7:0] CHR_NUL  = 8'h00;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_NINE = 8'h39;

	localparam logic [15:0] MAX_CYL     = 16'd255;
	localparam logic [15:0] MAX_HEADS   = 16'd2;
	localparam logic [15:0] MAX_SECT    = 16'd64;
	localparam logic [15:0] MIN_SSIZE   = 16'd128;
	localparam logic [15:0] MAX_SSIZE   = 16'd4096;

	typedef enum logic [2:0] {
		RSN_OK        = 3'd0,
		RSN_SHORT     = 3'd1,
		RSN_SIGNATURE = 3'd2,
		RSN_VERSION   = 3'd3,
		RSN_RANGE     = 3'd4,
		RSN_TRACK     = 3'd5,
		RSN_PARTIAL   = 3'd6,
		RSN_GEOMETRY  = 3'd7
	} reason_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_req;
		logic [31:0] file_span;
	} hdr_beat_t;

	typedef struct packed {
		logic        accepted;
		reason_t     reason;
		logic [7:0]  cylinder_count;
		logic [1:0]  head_count;
		logic [6:0]  sectors_per_track;
		logic [12:0] bytes_per_sector;
		logic [26:0] payload_bytes;
	} verdict_t;

	// header snapshot handed from the parser to the judge
	typedef struct packed {
		logic        short_span;
		logic        sig_good;
		logic        ver_good;
		logic [15:0] cyl;
		logic [15:0] heads;
		logic [15:0] sectors;
		logic [15:0] sec_size;
		logic [15:0] track;
	} geom_snap_t;

	function automatic logic [7:0] banner_byte(input logic [4:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = 8'h53;
			5'd1:    b = 8'h41;
			5'd2:    b = 8'h42;
			5'd3:    b = 8'h20;
			5'd4:    b = 8'h44;
			5'd5:    b = 8'h69;
			5'd6:    b = 8'h73;
			5'd7:    b = 8'h6B;
			5'd8:    b = 8'h65;
			5'd9:    b = 8'h74;
			5'd10:   b = 8'h74;
			5'd11:   b = 8'h65;
			5'd12:   b = 8'h20;
			5'd13:   b = 8'h55;
			5'd14:   b = 8'h74;
			5'd15:   b = 8'h69;
			5'd16:   b = 8'h6C;
			5'd17:   b = 8'h69;
			5'd18:   b = 8'h74;
			5'd19:   b = 8'h79;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/core/disk_image_header_validator.sv
// disk image header validator
// hdr channel: one header byte per beat, offsets 0 to 45 in order; start_req
//   marks offset 0 and loads file_span (taken in its low SPAN_BITS bits).
//   a start beat in mid-header throws the partial header away and restarts.
//   beats with start_req low while idle are dropped without a verdict.
// verdict channel: one beat per header, carrying accepted, a reason code
//   and, when accepted, the geometry and payload size.
// throughput: one header byte per cycle while hdr_stall is low, set by the single
//   parse register stage; headers may follow back to back.
// verdict path: the beat holding offset 45 is registered in the parse snapshot,
//   then judged into the output register, where the verdict becomes valid.
//   a start beat with a span of 46 or less answers reason 1 by the same path
//   and the block goes back to waiting for a start.
// stall: while verdict_stall holds a pending verdict, one more finished
//   header may wait in the snapshot stage; hdr_stall rises only when both
//   the snapshot and the output register are full.
// reset: arst_n clears all control state at once; the block comes out idle,
//   waiting for a start beat, with no verdict pending.
`default_nettype none

module disk_image_header_validator import dihv_pkg::*; #(
	parameter int SPAN_BITS = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            hdr_valid,
	input  wire hdr_beat_t hdr,
	output logic           hdr_stall,
	output logic           verdict_valid,
	output verdict_t       verdict,
	input  wire            verdict_stall
);

	// snapshot stage between parser and judge
	logic                 valid_s1;
	geom_snap_t           snap_s1;
	logic [SPAN_BITS-1:0] payload_s1;
	// judge frees the snapshot when the output register can take it
	logic                 advance;

	// byte-wise parse: banner, version, geometry fields
	dihv_parser #(
		.SPAN_BITS (SPAN_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr_valid  (hdr_valid),
		.hdr        (hdr),
		.hdr_stall  (hdr_stall),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.snap_s1    (snap_s1),
		.payload_s1 (payload_s1)
	);

	// range and consistency checks, result register
	dihv_judge #(
		.SPAN_BITS (SPAN_BITS)
	) u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.snap_s1       (snap_s1),
		.payload_s1    (payload_s1),
		.advance       (advance),
		.verdict_valid (verdict_valid),
		.verdict       (verdict),
		.verdict_stall (verdict_stall)
	);

endmodule

`default_nettype wire

### rtl/core/dihv_parser.sv
`default_nettype none

`include "disk_image_header_validator_assert.svh"

module dihv_parser import dihv_pkg::*; #(
	parameter int SPAN_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  hdr_valid,
	input  wire hdr_beat_t       hdr,
	output logic                 hdr_stall,
	input  wire                  advance,
	output logic                 valid_s1,
	output geom_snap_t           snap_s1,
	output logic [SPAN_BITS-1:0] payload_s1
);

	logic [5:0]           idx_q;
	logic                 waiting_q;
	logic [SPAN_BITS-1:0] span_q;
	logic                 sig_q, ver_q;
	logic [15:0]          cyl_q, heads_q, sect_q, ssize_q, track_q;

	logic                 take;
	logic [SPAN_BITS-1:0] span_in;
	logic                 span_short;
	logic [5:0]           idx_e;
	logic                 sig_n, ver_n;
	logic [15:0]          cyl_n, heads_n, sect_n, ssize_n, track_n;
	logic                 process, last_byte;

	function automatic logic [15:0] put_le(input logic [15:0] f, input logic [5:0] idx,
			input logic [5:0] lo, input logic [7:0] b);
		logic [15:0] r;
		r = f;
		if (idx == lo)
			r = {f[15:8], b};
		else if (idx == lo + 6'd1)
			r = {b, f[7:0]};
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHR_ZERO) && (b <= CHR_NINE);
	endfunction

	assign hdr_stall = valid_s1 && !advance;
	assign take      = hdr_valid && !hdr_stall;

	assign span_in    = SPAN_BITS'(hdr.file_span);
	assign span_short = span_in <= SPAN_BITS'(HDR_LEN);

	// byte is used when parsing, or when a start beat carries a long enough span
	assign process   = hdr.start_req ? !span_short : !waiting_q;
	assign last_byte = idx_e >= 6'(LAST_IDX);

	always_comb begin
		logic        sig_e, ver_e;
		logic [15:0] cyl_e, heads_e, sect_e, ssize_e, track_e;
		idx_e   = hdr.start_req ? 6'd0 : idx_q;
		sig_e   = hdr.start_req ? 1'b1 : sig_q;
		ver_e   = hdr.start_req ? 1'b1 : ver_q;
		cyl_e   = hdr.start_req ? 16'd0 : cyl_q;
		heads_e = hdr.start_req ? 16'd0 : heads_q;
		sect_e  = hdr.start_req ? 16'd0 : sect_q;
		ssize_e = hdr.start_req ? 16'd0 : ssize_q;
		track_e = hdr.start_req ? 16'd0 : track_q;

		sig_n = sig_e;
		ver_n = ver_e;
		if (idx_e < 6'(BANNER_LEN)) begin
			if (hdr.data_byte != banner_byte(idx_e[4:0]))
				sig_n = 1'b0;
		end else if (idx_e == 6'(VER_DOT_AT)) begin
			if (hdr.data_byte != CHR_DOT)
				ver_n = 1'b0;
		end else if (idx_e == 6'(VER_MAJOR) || idx_e == 6'(VER_MIN_HI)
				|| idx_e == 6'(VER_MIN_LO)) begin
			if (!is_digit(hdr.data_byte))
				ver_n = 1'b0;
		end else if (idx_e == 6'(VER_NUL_AT)) begin
			if (hdr.data_byte != CHR_NUL)
				ver_n = 1'b0;
		end

		cyl_n   = put_le(cyl_e,   idx_e, 6'(CYL_LO),   hdr.data_byte);
		heads_n = put_le(heads_e, idx_e, 6'(HEADS_LO), hdr.data_byte);
		sect_n  = put_le(sect_e,  idx_e, 6'(SECT_LO),  hdr.data_byte);
		ssize_n = put_le(ssize_e, idx_e, 6'(SSIZE_LO), hdr.data_byte);
		track_n = put_le(track_e, idx_e, 6'(TRACK_LO), hdr.data_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			waiting_q <= 1'b1;
			span_q    <= '0;
			sig_q     <= 1'b1;
			ver_q     <= 1'b1;
			cyl_q     <= '0;
			heads_q   <= '0;
			sect_q    <= '0;
			ssize_q   <= '0;
			track_q   <= '0;
		end else if (take) begin
			if (hdr.start_req)
				span_q <= span_in;
			if (hdr.start_req && span_short) begin
				idx_q     <= '0;
				waiting_q <= 1'b1;
				sig_q     <= 1'b1;
				ver_q     <= 1'b1;
				cyl_q     <= '0;
				heads_q   <= '0;
				sect_q    <= '0;
				ssize_q   <= '0;
				track_q   <= '0;
			end else if (process) begin
				sig_q   <= sig_n;
				ver_q   <= ver_n;
				cyl_q   <= cyl_n;
				heads_q <= heads_n;
				sect_q  <= sect_n;
				ssize_q <= ssize_n;
				track_q <= track_n;
				if (last_byte) begin
					idx_q     <= '0;
					waiting_q <= 1'b1;
				end else begin
					idx_q     <= idx_e + 6'd1;
					waiting_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= (hdr.start_req && span_short) || (process && last_byte);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			snap_s1.short_span <= hdr.start_req && span_short;
			snap_s1.sig_good   <= sig_n;
			snap_s1.ver_good   <= ver_n;
			snap_s1.cyl        <= cyl_n;
			snap_s1.heads      <= heads_n;
			snap_s1.sectors    <= sect_n;
			snap_s1.sec_size   <= ssize_n;
			snap_s1.track      <= track_n;
			// span is above the header length whenever a full header completes
			payload_s1         <= span_q - SPAN_BITS'(HDR_LEN);
		end
	end

	`DIHV_ASSERT(a_idle_idx_zero, clk, arst_n, waiting_q |-> idx_q == 6'd0)
	`DIHV_ASSERT(a_idx_in_header, clk, arst_n, !waiting_q |-> idx_q <= 6'(LAST_IDX))
	`DIHV_ASSERT_MSG(a_s1_holds, clk, arst_n, valid_s1 && !advance |=> valid_s1,
		"snapshot dropped while output stalled")

endmodule

`default_nettype wire

### rtl/core/dihv_judge.sv
`default_nettype none

`include "disk_image_header_validator_assert.svh"

module dihv_judge import dihv_pkg::*; #(
	parameter int SPAN_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid_s1,
	input  wire geom_snap_t      snap_s1,
	input  wire [SPAN_BITS-1:0]  payload_s1,
	output logic                 advance,
	output logic                 verdict_valid,
	output verdict_t             verdict,
	input  wire                  verdict_stall
);

	logic        range_bad, track_bad, partial, too_big;
	logic [19:0] track_calc;
	logic [23:0] cyl_track;
	logic [24:0] capacity;
	logic [12:0] sec_mask;
	reason_t     rsn;
	verdict_t    result;

	assign advance = !verdict_valid || !verdict_stall;

	always_comb begin
		range_bad = snap_s1.cyl == 16'd0 || snap_s1.cyl > MAX_CYL
			|| snap_s1.heads == 16'd0 || snap_s1.heads > MAX_HEADS
			|| snap_s1.sectors == 16'd0 || snap_s1.sectors > MAX_SECT
			|| snap_s1.sec_size < MIN_SSIZE || snap_s1.sec_size > MAX_SSIZE
			|| (snap_s1.sec_size & (snap_s1.sec_size - 16'd1)) != 16'd0;

		// narrow products are exact once the ranges hold
		track_calc = {13'd0, snap_s1.sectors[6:0]} * {7'd0, snap_s1.sec_size[12:0]};
		track_bad  = {4'd0, snap_s1.track} != track_calc;

		sec_mask = snap_s1.sec_size[12:0] - 13'd1;
		partial  = (payload_s1[12:0] & sec_mask) != 13'd0;

		cyl_track = {16'd0, snap_s1.cyl[7:0]} * {8'd0, snap_s1.track};
		capacity  = (snap_s1.heads[1:0] == 2'd2) ? {cyl_track, 1'b0} : {1'b0, cyl_track};
		too_big   = payload_s1 > SPAN_BITS'(capacity);

		if (snap_s1.short_span)
			rsn = RSN_SHORT;
		else if (!snap_s1.sig_good)
			rsn = RSN_SIGNATURE;
		else if (!snap_s1.ver_good)
			rsn = RSN_VERSION;
		else if (range_bad)
			rsn = RSN_RANGE;
		else if (track_bad)
			rsn = RSN_TRACK;
		else if (partial)
			rsn = RSN_PARTIAL;
		else if (too_big)
			rsn = RSN_GEOMETRY;
		else
			rsn = RSN_OK;

		result = '0;
		result.reason = rsn;
		if (rsn == RSN_OK) begin
			result.accepted          = 1'b1;
			result.cylinder_count    = snap_s1.cyl[7:0];
			result.head_count        = snap_s1.heads[1:0];
			result.sectors_per_track = snap_s1.sectors[6:0];
			result.bytes_per_sector  = snap_s1.sec_size[12:0];
			result.payload_bytes     = payload_s1[26:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid <= 1'b0;
		end else if (advance) begin
			verdict_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			verdict <= result;
	end

	`DIHV_ASSERT(a_ok_sector_pow2, clk, arst_n,
		verdict_valid && verdict.accepted |-> $onehot(verdict.bytes_per_sector))
	`DIHV_ASSERT_MSG(a_reject_zeroed, clk, arst_n,
		verdict_valid && !verdict.accepted |->
			verdict.payload_bytes == 27'd0 && verdict.cylinder_count == 8'd0,
		"rejected verdict carries geometry")

endmodule

`default_nettype wire
